[hw/rtl/tfv_pkg.sv]
package tfv_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_CELLS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int SQRT_STEPS   = 16;
    localparam int NUM_CELLS    = (CORDIC_CELLS > SQRT_STEPS) ? CORDIC_CELLS : SQRT_STEPS;
    localparam int LATENCY      = NUM_CELLS + 5;

    localparam int XW       = 16;
    localparam int CW       = 34;
    localparam int RW       = 32;
    localparam int STEP_W   = 5;
    localparam int SHAMT_W  = 5;
    localparam int SHIFT_IN = 14;
    localparam int SQ_TOP   = 30;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;
    localparam int HOLD_W   = 15;
    localparam int GAIN_W   = 16;
    localparam int BRG_W    = 16;
    localparam int ERR_W    = 17;

    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] BRG_ROUND   = 34'sd65536;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 15'd512;
    localparam logic [GAIN_W-1:0] ANG_RESET  = 16'd1280;
    localparam logic [GAIN_W-1:0] LIN_RESET  = 16'd256;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [IDX_W-1:0] {
        REG_HOLD = 2'd0,
        REG_ANG  = 2'd1,
        REG_LIN  = 2'd2,
        REG_EN   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                 vld;
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [RW-1:0]        n;
        logic [RW-1:0]        root;
    } tfv_cell_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold;
        logic [GAIN_W-1:0] ang;
        logic [GAIN_W-1:0] lin;
        logic              en;
    } tfv_cfg_t;

    function automatic logic signed [CW-1:0] atan_const(input step_t s);
        logic signed [CW-1:0] a;
        unique case (s)
            5'd0:    a = 34'sd843314856;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043836;
            5'd3:    a = 34'sd133525158;
            5'd4:    a = 34'sd67021686;
            5'd5:    a = 34'sd33543515;
            5'd6:    a = 34'sd16775850;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194282;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048575;
            5'd11:   a = 34'sd524287;
            5'd12:   a = 34'sd262143;
            5'd13:   a = 34'sd131071;
            5'd14:   a = 34'sd65535;
            5'd15:   a = 34'sd32767;
            5'd16:   a = 34'sd16383;
            5'd17:   a = 34'sd8191;
            5'd18:   a = 34'sd4095;
            5'd19:   a = 34'sd2047;
            5'd20:   a = 34'sd1023;
            5'd21:   a = 34'sd511;
            5'd22:   a = 34'sd255;
            5'd23:   a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[hw/rtl/tfv_front.sv]
module tfv_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic signed [15:0]        target_x,
    input  logic signed [15:0]        target_y,
    output tfv_pkg::tfv_cell_t        q
);
    import tfv_pkg::*;

    logic                 vld1_reg, vld1_next;
    logic                 zero1_reg, zero1_next;
    logic signed [CW-1:0] x1_reg, x1_next;
    logic signed [CW-1:0] y1_reg, y1_next;
    logic signed [CW-1:0] z1_reg, z1_next;
    logic [RW-1:0]        sqx1_reg, sqx1_next;
    logic [RW-1:0]        sqy1_reg, sqy1_next;
    tfv_cell_t            q_reg, q_next;

    logic signed [CW-1:0] xs, ys;
    logic signed [RW-1:0] px, py;

    // scale by 2^14, then fold the left half plane onto the right one
    always_comb
    begin
        xs = CW'($signed({target_x, {SHIFT_IN{1'b0}}}));
        ys = CW'($signed({target_y, {SHIFT_IN{1'b0}}}));
        px = RW'(target_x) * RW'(target_x);
        py = RW'(target_y) * RW'(target_y);
        vld1_next  = load;
        zero1_next = (target_x == '0) && (target_y == '0);
        sqx1_next  = RW'(px);
        sqy1_next  = RW'(py);
        if (!target_x[XW-1])
        begin
            x1_next = xs;
            y1_next = ys;
            z1_next = '0;
        end
        else if (!target_y[XW-1])
        begin
            x1_next = ys;
            y1_next = -xs;
            z1_next = HALF_PI_Q30;
        end
        else
        begin
            x1_next = -ys;
            y1_next = xs;
            z1_next = -HALF_PI_Q30;
        end
    end

    // sum of squares
    always_comb
    begin
        q_next.vld  = vld1_reg;
        q_next.zero = zero1_reg;
        q_next.x    = x1_reg;
        q_next.y    = y1_reg;
        q_next.z    = z1_reg;
        q_next.n    = sqx1_reg + sqy1_reg;
        q_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            q_reg    <= '0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero1_reg <= zero1_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        z1_reg    <= z1_next;
        sqx1_reg  <= sqx1_next;
        sqy1_reg  <= sqy1_next;
    end

    assign q = q_reg;

endmodule

[hw/rtl/tfv_cell.sv]
module tfv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tfv_pkg::step_t     step,
    input  tfv_pkg::tfv_cell_t d,
    output tfv_pkg::tfv_cell_t q
);
    import tfv_pkg::*;

    tfv_cell_t            q_reg, q_next;
    logic signed [CW-1:0] dx, dy, da;
    logic [SHAMT_W-1:0]   shamt;
    logic [RW-1:0]        sq_bit, trial;

    always_comb
    begin
        q_next = d;
        dx     = d.y >>> step;
        dy     = d.x >>> step;
        da     = atan_const(step);
        shamt  = SHAMT_W'(SQ_TOP - 2 * int'(step));
        sq_bit = RW'(1) << shamt;
        trial  = d.root + sq_bit;

        // one vectoring rotation
        if (step < STEP_W'(CORDIC_CELLS))
        begin
            if (!d.y[CW-1])
            begin
                q_next.x = d.x + dx;
                q_next.y = d.y - dy;
                q_next.z = d.z + da;
            end
            else
            begin
                q_next.x = d.x - dx;
                q_next.y = d.y + dy;
                q_next.z = d.z - da;
            end
        end

        // one root bit
        if (step < STEP_W'(SQRT_STEPS))
        begin
            if (d.n >= trial)
            begin
                q_next.n    = d.n - trial;
                q_next.root = (d.root >> 1) + sq_bit;
            end
            else
            begin
                q_next.root = d.root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[hw/rtl/tfv_back.sv]
module tfv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfv_pkg::tfv_cell_t   d,
    input  tfv_pkg::tfv_cfg_t    cfg,
    output logic                 done,
    output logic signed [15:0]   turn_rate,
    output logic signed [15:0]   forward_speed,
    output logic                 drive_valid
);
    import tfv_pkg::*;

    localparam int TP_W = GAIN_W + 1 + BRG_W;
    localparam int SP_W = GAIN_W + 1 + ERR_W;
    localparam int RS_W = SP_W + 1;

    logic                    vld1_reg, vld1_next;
    logic signed [BRG_W-1:0] brg_reg, brg_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                    vld2_reg, vld2_next;
    logic signed [TP_W-1:0]  tp_reg, tp_next;
    logic signed [SP_W-1:0]  sp_reg, sp_next;
    logic                    done_reg, done_next;
    logic                    dv_reg, dv_next;
    logic signed [XW-1:0]    turn_reg, turn_next;
    logic signed [XW-1:0]    speed_reg, speed_next;

    logic signed [CW-1:0]    zr;
    logic signed [RS_W-1:0]  tr, sr;

    function automatic logic signed [XW-1:0] sat16(input logic signed [RS_W-1:0] v);
        logic signed [XW-1:0] r;
        if (v > RS_W'(32767))
        begin
            r = 16'sh7fff;
        end
        else if (v < -RS_W'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = XW'(v);
        end
        return r;
    endfunction

    // bearing to q3.13, range error
    always_comb
    begin
        zr        = d.z + BRG_ROUND;
        vld1_next = d.vld;
        brg_next  = d.zero ? '0 : zr[CW-2:CW-1-BRG_W];
        err_next  = $signed({1'b0, d.root[XW-1:0]}) - $signed({2'b00, cfg.hold});
    end

    // gain products
    always_comb
    begin
        vld2_next = vld1_reg;
        tp_next   = TP_W'($signed({1'b0, cfg.ang})) * TP_W'(brg_reg);
        sp_next   = SP_W'($signed({1'b0, cfg.lin})) * SP_W'(err_reg);
    end

    // round half up, saturate, gate by enable
    always_comb
    begin
        tr         = (RS_W'(tp_reg) + RS_W'(4096)) >>> 13;
        sr         = (RS_W'(sp_reg) + RS_W'(128)) >>> 8;
        done_next  = vld2_reg;
        dv_next    = vld2_reg && cfg.en;
        turn_next  = cfg.en ? sat16(tr) : '0;
        speed_next = cfg.en ? sat16(sr) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            done_reg <= 1'b0;
            dv_reg   <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
            done_reg <= done_next;
            dv_reg   <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        brg_reg   <= brg_next;
        err_reg   <= err_next;
        tp_reg    <= tp_next;
        sp_reg    <= sp_next;
        turn_reg  <= turn_next;
        speed_reg <= speed_next;
    end

    assign done          = done_reg;
    assign drive_valid   = dv_reg;
    assign turn_rate     = turn_reg;
    assign forward_speed = speed_reg;

endmodule

[hw/rtl/target_follow_velocity_unit.sv]
// done rises once a word has passed the front registers, the row of cordic/root cells and the back registers
// throughput: one word per cycle, busy stays low; set by the row of cordic/root cells
// the receiver cannot stall: each result shows for one cycle with done high
// reset: rst_n asynchronous, active low; clears the pipeline valids and loads
// the register defaults (hold 2.0, angular gain 5.0, linear gain 1.0, follow on)
module target_follow_velocity_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [15:0]       target_x,
    input  logic signed [15:0]       target_y,
    output logic                     done,
    output logic signed [15:0]       turn_rate,
    output logic signed [15:0]       forward_speed,
    output logic                     drive_valid,
    input  logic                     cfg_we,
    input  logic [tfv_pkg::IDX_W-1:0] cfg_index,
    input  logic [tfv_pkg::CFG_W-1:0] cfg_data
);
    import tfv_pkg::*;

    tfv_cfg_t  cfg_reg, cfg_next;
    tfv_cell_t chain [NUM_CELLS+1];
    logic      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_HOLD: cfg_next.hold = cfg_data[HOLD_W-1:0];
                REG_ANG:  cfg_next.ang  = cfg_data[GAIN_W-1:0];
                REG_LIN:  cfg_next.lin  = cfg_data[GAIN_W-1:0];
                REG_EN:   cfg_next.en   = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold <= HOLD_RESET;
            cfg_reg.ang  <= ANG_RESET;
            cfg_reg.lin  <= LIN_RESET;
            cfg_reg.en   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tfv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .target_x (target_x),
        .target_y (target_y),
        .q        (chain[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        tfv_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (STEP_W'(k)),
            .d     (chain[k]),
            .q     (chain[k+1])
        );
    end

    tfv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .d             (chain[NUM_CELLS]),
        .cfg           (cfg_reg),
        .done          (done),
        .turn_rate     (turn_rate),
        .forward_speed (forward_speed),
        .drive_valid   (drive_valid)
    );

endmodule

[hw/rtl/tfv_checker.sv]
module tfv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] turn_rate,
    input logic signed [15:0] forward_speed,
    input logic               drive_valid
);
    import tfv_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted word");

    a_valid_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> done)
        else $error("drive_valid without done");

    a_stop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !drive_valid) |-> (turn_rate == '0 && forward_speed == '0))
        else $error("nonzero drive while stopped");

endmodule

bind target_follow_velocity_unit tfv_checker u_tfv_checker (.*);
